>>> rtl/mld_pkg.sv
`default_nettype none
package mld_pkg;
  localparam int unsigned NumChan = 32;
  localparam int unsigned ChanBits = 5;
  localparam int unsigned MaxFrames = 4096;
  localparam int unsigned FrameBits = 13;
  localparam int unsigned SampleBits = 24;
  localparam int unsigned CoeffBits = 17;
  localparam int unsigned FracBits = 16;
  localparam int unsigned SumBits = 60;
  localparam logic [CoeffBits-1:0] Unity = 17'h10000;
  localparam logic [SampleBits-1:0] FullScale = 24'h800000;

  localparam logic [1:0] RegMode = 2'd0;
  localparam logic [1:0] RegCount = 2'd1;
  localparam logic [1:0] RegAttack = 2'd2;
  localparam logic [1:0] RegRelease = 2'd3;

  typedef struct packed {
    logic [SampleBits-1:0] sample;
    logic [SampleBits-1:0] mag;
    logic [ChanBits-1:0] chan;
    logic last;
  } item_t;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_CALC, S_ENDDIV, S_ENDSQRT, S_ENDSM, S_OUT
  } bstate_t;
endpackage
`default_nettype wire

>>> rtl/mld_front.sv
`default_nettype none
module mld_front import mld_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [SampleBits-1:0] sample,
  input  wire logic last_in_block,
  input  wire logic [5:0] channel_count,
  output logic q_valid,
  input  wire logic q_stall,
  output item_t q_item
);
  logic [ChanBits-1:0] chan;
  logic [5:0] ch;
  logic [ChanBits-1:0] c;
  logic [5:0] c1;
  item_t fifo [2];
  logic wp, rp;
  logic [1:0] cnt;
  logic push, pop;

  always_comb begin
    if (channel_count == 6'd0) ch = 6'd2;
    else if (channel_count > 6'd32) ch = 6'd32;
    else ch = channel_count;
    c = ({1'b0, chan} >= ch) ? '0 : chan;
    c1 = {1'b0, c} + 6'd1;
  end

  assign in_stall = (cnt == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt != 2'd0);
  assign pop = q_valid && !q_stall;
  assign q_item = fifo[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wp].sample <= sample;
      fifo[wp].mag <= sample[SampleBits-1] ? (~sample + 1'b1) : sample;
      fifo[wp].chan <= c;
      fifo[wp].last <= last_in_block;
    end
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= '0;
      chan <= '0;
    end else begin
      if (push) begin
        wp <= ~wp;
        chan <= (last_in_block || c1 >= ch) ? '0 : c1[ChanBits-1:0];
      end
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

>>> rtl/mld_back.sv
`default_nettype none
module mld_back import mld_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  output logic q_stall,
  input  item_t q_item,
  input  wire logic detect_mode,
  input  wire logic [5:0] channel_count,
  input  wire logic [CoeffBits-1:0] attack_factor,
  input  wire logic [CoeffBits-1:0] release_factor,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [SampleBits-1:0] sample_out,
  output logic [SampleBits-1:0] level,
  output logic level_valid
);
  logic [SampleBits-1:0] env_mem [NumChan];
  logic [SumBits-1:0] sum_mem [NumChan];
  logic [NumChan-1:0] sum_ok;
  logic [NumChan-1:0] env_ok;
  bstate_t state, state_next;
  item_t it;
  logic [SampleBits-1:0] env_rd;
  logic [SampleBits-1:0] env_cur;
  logic [SumBits-1:0] sum_rd;
  logic [FrameBits-1:0] frames;
  logic [SampleBits-1:0] block_max, held_level;
  logic [ChanBits-1:0] ei;
  logic [5:0] ch;
  logic [SumBits-1:0] rem, quo;
  logic [6:0] dcnt;
  logic [SumBits-1:0] sq_v, sq_res, sq_bit;
  logic [SumBits-1:0] sq_mag;
  logic [SampleBits-1:0] tgt, newenv;
  logic [CoeffBits-1:0] ka, kr, k;
  logic [SampleBits-1:0] diff;
  logic [SampleBits+CoeffBits-1:0] prod;
  logic [SumBits-1:0] eff_sum;
  logic [SumBits:0] sum_add;
  logic [FrameBits-1:0] fdiv;
  logic [SumBits+FrameBits-1:0] trial;

  always_comb begin
    if (channel_count == 6'd0) ch = 6'd2;
    else if (channel_count > 6'd32) ch = 6'd32;
    else ch = channel_count;
    ka = (attack_factor > Unity) ? Unity : attack_factor;
    kr = (release_factor > Unity) ? Unity : release_factor;
    env_cur = env_ok[(state == S_CALC) ? it.chan : ei] ? env_rd : '0;
    k = (state == S_CALC && !(tgt > env_cur)) ? kr : ka;
    diff = (tgt > env_cur) ? tgt - env_cur : env_cur - tgt;
    prod = {{CoeffBits{1'b0}}, diff} * {{SampleBits{1'b0}}, k};
    newenv = (tgt > env_cur) ? env_cur + prod[FracBits +: SampleBits]
                             : env_cur - prod[FracBits +: SampleBits];
    sq_mag = SumBits'(it.mag) * SumBits'(it.mag);
    eff_sum = sum_ok[it.chan] ? sum_rd : '0;
    sum_add = {1'b0, eff_sum} + {1'b0, sq_mag};
    fdiv = (frames == '0) ? FrameBits'(1) : frames;
    trial = {{FrameBits{1'b0}}, rem[SumBits-2:0], quo[SumBits-1]}
            - {{SumBits{1'b0}}, fdiv};
  end

  // target: mag in peak step, clamped root at block end
  always_comb begin
    if (state == S_CALC) tgt = it.mag;
    else tgt = (sq_res > SumBits'(FullScale)) ? FullScale : sq_res[SampleBits-1:0];
  end

  assign q_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (q_valid) state_next = S_RD;
      S_RD: state_next = S_CALC;
      S_CALC: state_next = (it.last && detect_mode) ? S_ENDDIV : S_OUT;
      S_ENDDIV: if (dcnt == 7'd0) state_next = S_ENDSQRT;
      S_ENDSQRT: if (sq_bit == '0) state_next = S_ENDSM;
      S_ENDSM: state_next = ({1'b0, ei} + 6'd1 >= ch) ? S_OUT : S_ENDDIV;
      S_OUT: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) it <= q_item;
    env_rd <= env_mem[(state == S_RD) ? it.chan : ei];
    sum_rd <= sum_mem[(state == S_RD) ? it.chan : ei];
    case (state)
      S_CALC: begin
        if (!detect_mode) env_mem[it.chan] <= newenv;
        else sum_mem[it.chan] <= sum_add[SumBits] ? {SumBits{1'b1}} : sum_add[SumBits-1:0];
        ei <= '0;
        quo <= '0;
        rem <= '0;
        dcnt <= 7'(SumBits + 2);
      end
      S_ENDDIV: begin
        if (dcnt == 7'd0) begin
          sq_v <= quo;
          sq_res <= '0;
          sq_bit <= SumBits'(1) << (SumBits - 2);
        end else begin
          // the first step of the count waits for the sum read
          if (dcnt == 7'(SumBits + 1)) begin
            quo <= sum_ok[ei] ? sum_rd : '0;
            rem <= '0;
          end else if (dcnt <= 7'(SumBits)) begin
            if (!trial[SumBits+FrameBits-1]) begin
              rem <= trial[SumBits-1:0];
              quo <= {quo[SumBits-2:0], 1'b1};
            end else begin
              rem <= {rem[SumBits-2:0], quo[SumBits-1]};
              quo <= {quo[SumBits-2:0], 1'b0};
            end
          end
          dcnt <= dcnt - 7'd1;
        end
      end
      S_ENDSQRT: begin
        if (sq_bit != '0) begin
          if (sq_v >= sq_res + sq_bit) begin
            sq_v <= sq_v - (sq_res + sq_bit);
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
        end
      end
      S_ENDSM: begin
        env_mem[ei] <= newenv;
        ei <= ei + 1'b1;
        dcnt <= 7'(SumBits + 2);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_ok <= '0;
      env_ok <= '0;
      frames <= '0;
      block_max <= '0;
      held_level <= '0;
      out_valid <= 1'b0;
      level_valid <= 1'b0;
    end else begin
      if (state == S_CALC) begin
        sample_out <= it.sample;
        level_valid <= it.last;
        out_valid <= !(it.last && detect_mode);
        if (!detect_mode) env_ok[it.chan] <= 1'b1;
        if (it.last && !detect_mode) begin
          held_level <= (newenv > block_max) ? newenv : block_max;
          block_max <= '0;
          sum_ok <= '0;
          frames <= '0;
        end else begin
          if (it.chan == '0 && frames < FrameBits'(MaxFrames)) frames <= frames + 1'b1;
          if (!detect_mode && newenv > block_max) block_max <= newenv;
          if (detect_mode) sum_ok[it.chan] <= 1'b1;
          if (it.last) held_level <= '0;
        end
      end
      if (state == S_ENDSM) begin
        env_ok[ei] <= 1'b1;
        if (newenv > held_level) held_level <= newenv;
        if ({1'b0, ei} + 6'd1 >= ch) begin
          out_valid <= 1'b1;
          sum_ok <= '0;
          frames <= '0;
          block_max <= '0;
        end
      end
      if (state == S_OUT && !out_stall) out_valid <= 1'b0;
    end
  end

  assign level = held_level;
endmodule
`default_nettype wire

>>> rtl/multichannel_level_detector_top.sv
`default_nettype none
// channel  direction  handshake
// in       input      in_valid / in_stall, sample, last_in_block
// out      output     out_valid / out_stall, sample_out, level, level_valid
// cfg      input      cfg_we, cfg_index, cfg_data
// the back end takes one item at a time through queue read, memory read, update, output
// a block end in rms mode adds a divide, a root and an envelope update per active channel
// reset is synchronous; envelope and sum memories read as zero through valid bits
// the two-entry queue lets the input run ahead while the back end is busy or stalled
module multichannel_level_detector_top import mld_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [SampleBits-1:0] sample,
  input  wire logic last_in_block,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [SampleBits-1:0] sample_out,
  output logic [SampleBits-1:0] level,
  output logic level_valid,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [CoeffBits-1:0] cfg_data
);
  logic detect_mode;
  logic [5:0] channel_count;
  logic [CoeffBits-1:0] attack_factor, release_factor;
  logic q_valid, q_stall;
  item_t q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      detect_mode <= 1'b0;
      channel_count <= 6'd2;
      attack_factor <= 17'd136;
      release_factor <= 17'd14;
    end else if (cfg_we) begin
      case (cfg_index)
        RegMode: detect_mode <= cfg_data[0];
        RegCount: channel_count <= cfg_data[5:0];
        RegAttack: attack_factor <= cfg_data;
        RegRelease: release_factor <= cfg_data;
        default: ;
      endcase
    end
  end

  mld_front u_front (
    .clk, .rst, .in_valid, .in_stall, .sample, .last_in_block, .channel_count,
    .q_valid, .q_stall, .q_item
  );

  mld_back u_back (
    .clk, .rst, .q_valid, .q_stall, .q_item, .detect_mode, .channel_count,
    .attack_factor, .release_factor, .out_valid, .out_stall, .sample_out,
    .level, .level_valid
  );

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample_out) && $stable(level_valid))
    else $error("output changed while stalled");
  a_level_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(level))
    else $error("level changed while stalled");
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    level <= FullScale)
    else $error("level above full scale");
endmodule
`default_nettype wire
